FILE: rtl/core/well512_pkg.sv
// Shared types, constants and command codes of the WELL512 generator.
`default_nettype none

package well512_pkg;

    localparam int WORD_W     = 32;
    localparam int POOL_DEPTH = 16;
    localparam int POOL_AW    = 4;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 23;
    localparam int MULT_W     = 15;
    localparam int CNT_W      = 5;

    localparam logic [WORD_W-1:0]  TEMPER_MASK = 32'hDA44_2D24;
    localparam logic [MULT_W-1:0]  FRAC_MULT   = 15'd16807;

    localparam logic [POOL_AW-1:0] TAP_C       = 4'd13;
    localparam logic [POOL_AW-1:0] TAP_M       = 4'd9;
    localparam logic [POOL_AW-1:0] TAP_Q       = 4'd15;
    localparam logic [POOL_AW-1:0] SEED_LAST   = 4'd15;
    localparam logic [CNT_W-1:0]   DIV_LAST    = 5'd31;

    localparam logic [CMD_W-1:0] CMD_RESEED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RAW    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FRAC   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_STEP  = 2'd1;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_RD_C,
        OP_RD_M,
        OP_RD_Q,
        OP_WR_Q,
        OP_SEED,
        OP_DIV,
        OP_MUL,
        OP_OUT_SEED,
        OP_OUT_RAW,
        OP_OUT_RANGE,
        OP_OUT_FRAC
    } t_dp_op;

    typedef struct packed {
        t_dp_op             op;
        logic               latch;
        logic [POOL_AW-1:0] seed_addr;
    } t_dp_cmd;

    typedef struct packed {
        logic span_zero;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/core/well512_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module well512_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/well512_dp.sv
// Datapath: state pool, tempering, range remainder unit, fraction multiply, output register.
`default_nettype none

module well512_dp import well512_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    input  wire logic [WORD_W-1:0]    i_low,
    input  wire logic [WORD_W-1:0]    i_high,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_status,
    output logic      [WORD_W-1:0]    o_value,
    output logic                      o_fault
);

    logic [WORD_W-1:0]     r_seed_start;
    logic [WORD_W-1:0]     r_seed_step;
    logic [POOL_AW-1:0]    r_pos;
    logic [POOL_DEPTH-1:0] r_valid;
    logic                  r_rd_ok;
    logic [WORD_W-1:0]     r_low;
    logic [WORD_W-1:0]     r_span;
    logic [WORD_W-1:0]     r_s;
    logic [WORD_W-1:0]     r_a;
    logic [WORD_W-1:0]     r_b;
    logic [WORD_W-1:0]     r_c;
    logic [WORD_W-1:0]     r_d;
    logic [WORD_W-1:0]     r_draw;
    logic [WORD_W-1:0]     r_div_n;
    logic [WORD_W-1:0]     r_rem;
    logic [FRAC_W-1:0]     r_prod;
    logic [WORD_W-1:0]     r_value;
    logic                  r_fault;

    logic [POOL_AW-1:0]      w_rd_addr;
    logic                    w_wr_en;
    logic [POOL_AW-1:0]      w_wr_addr;
    logic [WORD_W-1:0]       w_wr_data;
    logic [WORD_W-1:0]       w_rd_raw;
    logic [WORD_W-1:0]       w_rd;
    logic [WORD_W-1:0]       w_c;
    logic [WORD_W-1:0]       w_new_a;
    logic [WORD_W-1:0]       w_out;
    logic [WORD_W:0]         w_trial;
    logic [WORD_W:0]         w_diff;
    logic [WORD_W+MULT_W-1:0] w_prod;

    assign w_rd    = r_rd_ok ? w_rd_raw : '0;
    assign w_c     = w_rd ^ (w_rd >> 11);
    assign w_new_a = r_b ^ w_c;
    assign w_out   = w_rd ^ r_b ^ r_d ^ (w_rd << 2) ^ (r_b << 18) ^ (r_c << 28);
    assign w_trial = {r_rem, r_div_n[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_span};
    assign w_prod  = r_draw * FRAC_MULT;

    always_comb begin
        case (i_cmd.op)
            OP_RD_C: w_rd_addr = r_pos + TAP_C;
            OP_RD_M: w_rd_addr = r_pos + TAP_M;
            OP_RD_Q: w_rd_addr = r_pos + TAP_Q;
            default: w_rd_addr = r_pos;
        endcase
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = w_new_a;
        case (i_cmd.op)
            OP_RD_Q: begin
                w_wr_en = 1'b1;
            end
            OP_WR_Q: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos + TAP_Q;
                w_wr_data = w_out;
            end
            OP_SEED: begin
                w_wr_en   = 1'b1;
                w_wr_addr = i_cmd.seed_addr;
                w_wr_data = r_s;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    well512_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    // Pool words never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_start <= '0;
            r_seed_step  <= '0;
            r_pos        <= '0;
            r_valid      <= '0;
            r_rd_ok      <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_SEED_START) begin
                r_seed_start <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_SEED_STEP) begin
                r_seed_step <= i_cfg_data;
            end
            if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            r_rd_ok <= r_valid[w_rd_addr];
            if (i_cmd.op == OP_WR_Q) begin
                r_pos <= r_pos + TAP_Q;
            end else if (i_cmd.op == OP_SEED) begin
                r_pos <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_low  <= i_low;
            r_span <= i_high - i_low;
            r_s    <= r_seed_start;
        end
        case (i_cmd.op)
            OP_RD_C: begin
                r_a <= w_rd;
            end
            OP_RD_M: begin
                r_b <= r_a ^ w_rd ^ (r_a << 16) ^ (w_rd << 15);
            end
            OP_RD_Q: begin
                r_c <= w_c;
                r_d <= w_new_a ^ ((w_new_a << 5) & TEMPER_MASK);
            end
            OP_WR_Q: begin
                r_draw  <= w_out;
                r_div_n <= w_out;
                r_rem   <= '0;
            end
            OP_SEED: begin
                r_s <= (r_s << 1) + r_seed_step;
            end
            OP_DIV: begin
                r_div_n <= r_div_n << 1;
                // Trial subtract: the partial remainder stays below the span.
                if (!w_diff[WORD_W]) begin
                    r_rem <= w_diff[WORD_W-1:0];
                end else begin
                    r_rem <= w_trial[WORD_W-1:0];
                end
            end
            OP_MUL: begin
                r_prod <= w_prod[FRAC_W-1:0];
            end
            OP_OUT_SEED: begin
                r_value <= '0;
                r_fault <= 1'b0;
            end
            OP_OUT_RAW: begin
                r_value <= r_draw;
                r_fault <= 1'b0;
            end
            OP_OUT_RANGE: begin
                if (r_span == '0) begin
                    r_value <= r_low;
                    r_fault <= 1'b1;
                end else begin
                    r_value <= r_low + r_rem;
                    r_fault <= 1'b0;
                end
            end
            OP_OUT_FRAC: begin
                if (r_prod == '0) begin
                    r_value <= '0;
                    r_fault <= 1'b1;
                end else begin
                    r_value <= {{(WORD_W-FRAC_W){1'b0}}, r_prod - 1'b1};
                    r_fault <= 1'b0;
                end
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

    assign o_status.span_zero = (r_span == '0);
    assign o_value            = r_value;
    assign o_fault            = r_fault;

    a_seed_fills_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SEED && i_cmd.seed_addr == SEED_LAST) |=> (&r_valid))
        else $error("pool not fully valid after reseed");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV && r_span != '0) |=> (r_rem < r_span))
        else $error("partial remainder reached the span");

    a_pos_steps_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_WR_Q) |=> (r_pos == $past(r_pos) + TAP_Q))
        else $error("position did not step back by one");

endmodule

`default_nettype wire

FILE: rtl/core/well512_ctrl.sv
// Controller: sequences pool reads and writes, reseed, remainder steps and result hand-off.
`default_nettype none

module well512_ctrl import well512_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [CMD_W-1:0] i_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_dp_status       i_status,
    output t_dp_cmd               o_dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_C,
        S_RD_M,
        S_RD_Q,
        S_WR_Q,
        S_SEED,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CMD_W-1:0] r_cmd;
    logic [CMD_W-1:0] n_cmd;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;
    logic             w_load;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state            = r_state;
        n_cnt              = r_cnt + 1'b1;
        n_cmd              = r_cmd;
        o_dp_cmd.op        = OP_IDLE;
        o_dp_cmd.latch     = 1'b0;
        o_dp_cmd.seed_addr = r_cnt[POOL_AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_dp_cmd.latch = w_accept;
                n_cnt          = '0;
                if (w_accept) begin
                    n_cmd   = i_cmd;
                    n_state = (i_cmd == CMD_RESEED) ? S_SEED : S_RD_C;
                end
            end
            S_RD_C: begin
                o_dp_cmd.op = OP_RD_C;
                n_state     = S_RD_M;
            end
            S_RD_M: begin
                o_dp_cmd.op = OP_RD_M;
                n_state     = S_RD_Q;
            end
            S_RD_Q: begin
                o_dp_cmd.op = OP_RD_Q;
                n_state     = S_WR_Q;
            end
            S_WR_Q: begin
                o_dp_cmd.op = OP_WR_Q;
                n_cnt       = '0;
                if (r_cmd == CMD_RANGE && !i_status.span_zero) begin
                    n_state = S_DIV;
                end else if (r_cmd == CMD_FRAC) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SEED: begin
                o_dp_cmd.op = OP_SEED;
                if (r_cnt[POOL_AW-1:0] == SEED_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_dp_cmd.op = OP_DIV;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_dp_cmd.op = OP_MUL;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_RESEED: o_dp_cmd.op = OP_OUT_SEED;
                        CMD_RAW:    o_dp_cmd.op = OP_OUT_RAW;
                        CMD_RANGE:  o_dp_cmd.op = OP_OUT_RANGE;
                        CMD_FRAC:   o_dp_cmd.op = OP_OUT_FRAC;
                        default:    o_dp_cmd.op = OP_OUT_RAW;
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cmd       <= CMD_RESEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted but controller stayed idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the hand-off state");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("pending result overwritten");

    a_seed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED) |-> !r_cnt[CNT_W-1])
        else $error("reseed counter past the pool depth");

endmodule

`default_nettype wire

FILE: rtl/core/well512_random_generator_top.sv
// Top level of the WELL512 random generator: controller, datapath and port wiring.
`default_nettype none

// WELL512 generator with a 16-word state pool held in a small RAM with one read and
// one write port. One request is worked on at a time and gives one result. A raw draw
// takes three dependent pool reads through the single read port and two writes;
// a fraction draw adds a multiply by 16807, a range draw with a non-zero span adds a
// restoring remainder unit retiring one bit per cycle, and a reseed writes one pool
// word per cycle. The block is ready again as soon as the result is registered,
// even if that result has not yet been taken. Configuration writes are always
// accepted; indexes beyond the seed step register are ignored.
module well512_random_generator_top import well512_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [WORD_W-1:0]    i_low,
    input  wire logic [WORD_W-1:0]    i_high,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [WORD_W-1:0]    o_value,
    output logic                      o_fault
);

    t_dp_cmd    w_dp_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    well512_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_dp_cmd    (w_dp_cmd)
    );

    well512_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_low       (i_low),
        .i_high      (i_high),
        .i_cmd       (w_dp_cmd),
        .o_status    (w_status),
        .o_value     (o_value),
        .o_fault     (o_fault)
    );

endmodule

`default_nettype wire
